[sv/sbpe_pkg.sv]
// sbpe_pkg: shared types and constants for the stern-brocot path encoder
// no dependencies

package sbpe_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned MAX_RUNS = 64;

	localparam logic DIR_LEFT  = 1'b0;
	localparam logic DIR_RIGHT = 1'b1;

	typedef logic [VALUE_WIDTH_DEF-1:0] sbpe_val_t;

	// input transaction: one fraction
	typedef struct packed {
		sbpe_val_t numerator;
		sbpe_val_t denominator;
	} sbpe_in_t;

	// output transaction: one run
	typedef struct packed {
		logic      direction;
		sbpe_val_t run_length;
		sbpe_val_t lower_num;
		sbpe_val_t lower_den;
		sbpe_val_t upper_num;
		sbpe_val_t upper_den;
		logic      empty_path;
		logic      bad_input;
		logic      last;
	} sbpe_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_EMIT,
		ST_FINAL
	} sbpe_state_t;

	// control from sequencer to divider
	typedef struct packed {
		logic start;
	} sbpe_div_ctl_t;

	typedef struct packed {
		logic done;
	} sbpe_div_sts_t;

endpackage

[sv/sbpe_if.sv]
// sbpe_if: valid/ready channel interface carrying a payload of type t
// no dependencies

interface sbpe_if #(
	parameter type t = logic
) ();
	logic valid;
	logic ready;
	t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/sbpe_div.sv]
// sbpe_div: restoring radix-2 divider, one quotient bit per cycle
// depends on sbpe_pkg

module sbpe_div #(
	parameter int unsigned W = sbpe_pkg::VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbpe_pkg::sbpe_div_ctl_t ctl,
	input  logic [W-1:0]          dividend,
	input  logic [W-1:0]          divisor,
	output sbpe_pkg::sbpe_div_sts_t sts,
	output logic [W-1:0]          quot,
	output logic [W-1:0]          rem
);
	import sbpe_pkg::*;

	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  q_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {r_q, q_q[W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				r_q <= diff[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign sts.done = done_q;
	assign quot     = q_q;
	assign rem      = r_q;
endmodule

[sv/stern_brocot_path_encode_unit.sv]
// stern_brocot_path_encode_unit: top level of the stern-brocot path encoder
// depends on sbpe_pkg, sbpe_if, sbpe_div

// Encodes a positive fraction numerator/denominator as its run-length path in
// the stern-brocot tree, one output transaction per run, the last one carrying
// the final enclosing bounds. The walk is the euclidean algorithm: each step
// starts the shared serial divider in ST_DIV, waits in ST_MUL for it to finish
// (the state that sees it finish also does the bound update, one multiply-add
// pair) and in ST_EMIT queues the run for output, waiting there while the
// output side stalls. A 32-bit input has up to about 47 quotients. Input ready
// is low for the whole walk. A zero operand yields one bad_input transaction;
// 1/1 (or k/k) yields one empty_path transaction.

module stern_brocot_path_encode_unit #(
	parameter int unsigned VALUE_WIDTH = sbpe_pkg::VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	sbpe_if.sink   in_ch,
	sbpe_if.source out_ch
);
	import sbpe_pkg::*;

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned IW = $clog2(MAX_RUNS + 1);

	sbpe_state_t state_q, state_d;

	logic [W-1:0] a_q, b_q;
	logic [W-1:0] ln_q, ld_q, rn_q, rd_q, mn_q, md_q;
	logic [W-1:0] len_q;
	logic         dir_q;                 // parity of euclid step
	logic [IW-1:0] cnt_q;                // runs found
	logic         ovalid_q;
	logic         o_dir_q, o_empty_q, o_bad_q, o_last_q;
	logic [W-1:0] o_run_q, o_ln_q, o_ld_q, o_un_q, o_ud_q;

	sbpe_div_ctl_t div_ctl;
	sbpe_div_sts_t div_sts;
	logic [W-1:0]  quot, rem;
	logic [W-1:0]  len_c;
	logic [W-1:0]  in_num, in_den;
	logic          more;
	logic          ovalid_set;

	assign in_num = W'(in_ch.data.numerator);
	assign in_den = W'(in_ch.data.denominator);

	sbpe_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (a_q),
		.divisor  (b_q),
		.sts      (div_sts),
		.quot     (quot),
		.rem      (rem)
	);

	// run length: quotient, less one on an exact division
	assign len_c = (rem == '0) ? quot - 1'b1 : quot;
	// walk continues while remainder nonzero and run budget left
	assign more  = (b_q != '0) && (cnt_q != IW'(MAX_RUNS));

	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;

	// a new output transaction is loaded: bad operand, non-last run or final run
	assign ovalid_set =
		((state_q == ST_IDLE) && in_ch.valid && in_ch.ready
			&& (in_num == '0 || in_den == '0))
		|| ((state_q == ST_EMIT) && (!ovalid_q || out_ch.ready) && len_q != '0
			&& cnt_q != '0)
		|| ((state_q == ST_FINAL) && (!ovalid_q || out_ch.ready));

	always_comb begin
		out_ch.data.direction  = o_dir_q;
		out_ch.data.run_length = sbpe_val_t'(o_run_q);
		out_ch.data.lower_num  = sbpe_val_t'(o_ln_q);
		out_ch.data.lower_den  = sbpe_val_t'(o_ld_q);
		out_ch.data.upper_num  = sbpe_val_t'(o_un_q);
		out_ch.data.upper_den  = sbpe_val_t'(o_ud_q);
		out_ch.data.empty_path = o_empty_q;
		out_ch.data.bad_input  = o_bad_q;
		out_ch.data.last       = o_last_q;
	end

	// next state and divider start
	always_comb begin
		state_d = state_q;
		div_ctl.start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid && in_ch.ready && in_num != '0 && in_den != '0) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!more) begin
					state_d = ST_FINAL;
				end else begin
					div_ctl.start = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (div_sts.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// pending run is emitted once we know if it is the last one
				if (!ovalid_q || out_ch.ready) begin
					state_d = ST_DIV;
				end
			end
			ST_FINAL: begin
				if (!ovalid_q || out_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			// loading a new transaction wins over retiring the old one
			if (ovalid_set) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						cnt_q <= '0;
					end
				end
				ST_EMIT: begin
					// hold the new run until the previous one is gone
					if ((!ovalid_q || out_ch.ready) && len_q != '0) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// pending run register: the run most recently found, not yet output
	logic         p_dir_q;
	logic [W-1:0] p_run_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					a_q   <= in_num;
					b_q   <= in_den;
					dir_q <= DIR_RIGHT;
					ln_q  <= '0;
					ld_q  <= W'(1);
					rn_q  <= W'(1);
					rd_q  <= '0;
					mn_q  <= W'(1);
					md_q  <= W'(1);
					o_dir_q   <= DIR_LEFT;
					o_run_q   <= '0;
					o_ln_q    <= '0;
					o_ld_q    <= '0;
					o_un_q    <= '0;
					o_ud_q    <= '0;
					o_empty_q <= 1'b0;
					o_bad_q   <= 1'b1;
					o_last_q  <= 1'b1;
				end
			end
			ST_MUL: begin
				if (div_sts.done) begin
					len_q <= len_c;
					a_q   <= b_q;
					b_q   <= rem;
					if (len_c != '0) begin
						if (dir_q == DIR_RIGHT) begin
							ln_q <= W'(rn_q * (len_c - 1'b1) + mn_q);
							ld_q <= W'(rd_q * (len_c - 1'b1) + md_q);
						end else begin
							rn_q <= W'(ln_q * (len_c - 1'b1) + mn_q);
							rd_q <= W'(ld_q * (len_c - 1'b1) + md_q);
						end
					end
				end
			end
			ST_EMIT: begin
				if (!ovalid_q || out_ch.ready) begin
					dir_q <= ~dir_q;
					mn_q  <= ln_q + rn_q;
					md_q  <= ld_q + rd_q;
					if (len_q != '0) begin
						if (cnt_q != '0) begin
							o_dir_q   <= p_dir_q;
							o_run_q   <= p_run_q;
							o_ln_q    <= '0;
							o_ld_q    <= '0;
							o_un_q    <= '0;
							o_ud_q    <= '0;
							o_empty_q <= 1'b0;
							o_bad_q   <= 1'b0;
							o_last_q  <= 1'b0;
						end
						p_dir_q <= dir_q;
						p_run_q <= len_q;
					end
				end
			end
			ST_FINAL: begin
				if (!ovalid_q || out_ch.ready) begin
					o_ln_q    <= ln_q;
					o_ld_q    <= ld_q;
					o_un_q    <= rn_q;
					o_ud_q    <= rd_q;
					o_bad_q   <= 1'b0;
					o_last_q  <= 1'b1;
					if (cnt_q == '0) begin
						o_dir_q   <= DIR_LEFT;
						o_run_q   <= '0;
						o_empty_q <= 1'b1;
					end else begin
						o_dir_q   <= p_dir_q;
						o_run_q   <= p_run_q;
						o_empty_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end
endmodule

[verif/tb_stern_brocot_path_encode_unit.sv]
// tb_stern_brocot_path_encode_unit: self-checking bench for the stern-brocot path encoder
// depends on sbpe_pkg, sbpe_if and stern_brocot_path_encode_unit

module tb_stern_brocot_path_encode_unit;
	import sbpe_pkg::*;

	localparam int unsigned N_RANDOM = 200;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES = 60;

	typedef sbpe_val_t val_t;
	typedef sbpe_in_t  frac_t;
	typedef sbpe_out_t run_t;

	// one fraction waiting to be accepted, with its hand-typed answer if it has one
	typedef struct {
		frac_t frac;
		bit    typed;
		run_t  answer;
	} pending_t;

	typedef struct {
		val_t num;
		val_t den;
		bit   typed;
	} row_t;

	logic clk;
	logic arst_n;

	sbpe_if #(.t(frac_t)) in_ch ();
	sbpe_if #(.t(run_t))  out_ch ();

	stern_brocot_path_encode_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	pending_t pending_q[$];
	run_t     runs_due_q[$];
	int       fail_count;
	int       idle_cycles;
	int       send_idle_pct;
	int       recv_stall_pct;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// predicted runs for one fraction, pushed onto the queue of runs due
	function automatic void predict_path(input frac_t f);
		logic [63:0] a, b, q, r, len, mn, md, ln, ld, un, ud;
		int          step;
		int          n_runs;
		run_t        it;
		a = 64'(f.numerator);
		b = 64'(f.denominator);
		ln = 0; ld = 1; un = 1; ud = 0;
		if (a == 0 || b == 0) begin
			it = '0;
			it.bad_input = 1'b1;
			it.last = 1'b1;
			runs_due_q.push_back(it);
			return;
		end
		mn = 1; md = 1;
		step = 0;
		n_runs = 0;
		while (b != 0 && n_runs < MAX_RUNS) begin
			q = a / b;
			r = a % b;
			len = (r == 0) ? q - 1 : q;
			if (len > 0) begin
				it = '0;
				// even quotient index walks right, odd walks left
				it.direction = (step % 2 == 0) ? DIR_RIGHT : DIR_LEFT;
				it.run_length = val_t'(len);
				if (it.direction == DIR_RIGHT) begin
					ln = un * (len - 1) + mn;
					ld = ud * (len - 1) + md;
				end else begin
					un = ln * (len - 1) + mn;
					ud = ld * (len - 1) + md;
				end
				mn = ln + un;
				md = ld + ud;
				runs_due_q.push_back(it);
				n_runs++;
			end
			a = b;
			b = r;
			step++;
		end
		if (n_runs == 0) begin
			it = '0;
			it.empty_path = 1'b1;
			runs_due_q.push_back(it);
		end
		// final bounds go on the newest run
		it = runs_due_q[$];
		it.lower_num = val_t'(ln);
		it.lower_den = val_t'(ld);
		it.upper_num = val_t'(un);
		it.upper_den = val_t'(ud);
		it.last = 1'b1;
		runs_due_q[$] = it;
	endfunction

	// typed answers for the rows whose result is obvious
	function automatic run_t typed_answer(input val_t n, input val_t d);
		run_t it;
		it = '0;
		it.last = 1'b1;
		if (n == 0 || d == 0) begin
			it.bad_input = 1'b1;
		end else begin
			it.empty_path = 1'b1;
			it.lower_den = val_t'(1);
			it.upper_num = val_t'(1);
		end
		return it;
	endfunction

	// random fraction, biased toward shapes that exercise the walk
	function automatic frac_t random_frac();
		frac_t       f;
		logic [63:0] n, d, nn;
		int          kind;
		kind = $urandom_range(99);
		if (kind < 8) begin
			f.numerator = ($urandom_range(1) == 0) ? val_t'(0) : val_t'($urandom);
			f.denominator = (f.numerator == 0 && $urandom_range(1) == 0) ?
				val_t'($urandom) : val_t'(0);
		end else if (kind < 13) begin
			f.numerator = val_t'($urandom_range(1, 1000));
			f.denominator = f.numerator;
		end else if (kind < 40) begin
			f.numerator = val_t'($urandom_range(1, 60));
			f.denominator = val_t'($urandom_range(1, 60));
		end else if (kind < 65) begin
			// build from a chain of small quotients: long paths
			n = $urandom_range(1, 3);
			d = 1;
			forever begin
				nn = n * $urandom_range(1, 3) + d;
				if (nn > 64'hFFFF_FFFF) break;
				d = n;
				n = nn;
			end
			if ($urandom_range(1) == 0) begin
				f.numerator = val_t'(n);
				f.denominator = val_t'(d);
			end else begin
				f.numerator = val_t'(d);
				f.denominator = val_t'(n);
			end
		end else begin
			f.numerator = val_t'($urandom);
			f.denominator = val_t'($urandom);
			if (f.numerator == 0) f.numerator = 1;
			if (f.denominator == 0) f.denominator = 1;
		end
		return f;
	endfunction

	// drive one fraction at falling edges until it is accepted
	task automatic send_frac(input frac_t f, input bit typed, input run_t ans);
		pending_t p;
		p.frac = f;
		p.typed = typed;
		p.answer = ans;
		pending_q.push_back(p);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= f;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
	endtask

	// random backpressure on the result side, changed at falling edges
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// input side: record accepted fractions and predict their runs
	always @(posedge clk) begin
		pending_t p;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (pending_q.size() == 0) begin
				$error("input transaction with nothing pending");
				fail_count++;
			end else begin
				p = pending_q.pop_front();
				if (p.typed) runs_due_q.push_back(p.answer);
				else predict_path(p.frac);
			end
		end
	end

	// output side: compare each run, field by field, with the oldest due
	always @(posedge clk) begin
		run_t e, g;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			g = out_ch.data;
			if (runs_due_q.size() == 0) begin
				$error("unexpected output transaction");
				fail_count++;
			end else begin
				e = runs_due_q.pop_front();
				if (g.direction !== e.direction) begin
					$error("direction exp %0d got %0d", e.direction, g.direction);
					fail_count++;
				end
				if (g.run_length !== e.run_length) begin
					$error("run_length exp %0d got %0d", e.run_length, g.run_length);
					fail_count++;
				end
				if (g.lower_num !== e.lower_num) begin
					$error("lower_num exp %0d got %0d", e.lower_num, g.lower_num);
					fail_count++;
				end
				if (g.lower_den !== e.lower_den) begin
					$error("lower_den exp %0d got %0d", e.lower_den, g.lower_den);
					fail_count++;
				end
				if (g.upper_num !== e.upper_num) begin
					$error("upper_num exp %0d got %0d", e.upper_num, g.upper_num);
					fail_count++;
				end
				if (g.upper_den !== e.upper_den) begin
					$error("upper_den exp %0d got %0d", e.upper_den, g.upper_den);
					fail_count++;
				end
				if (g.empty_path !== e.empty_path) begin
					$error("empty_path exp %0d got %0d", e.empty_path, g.empty_path);
					fail_count++;
				end
				if (g.bad_input !== e.bad_input) begin
					$error("bad_input exp %0d got %0d", e.bad_input, g.bad_input);
					fail_count++;
				end
				if (g.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, g.last);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[stern_brocot_path_encode_unit] ERROR");
			$finish;
		end
	end

	// directed rows: zero operands, root and its multiples, extremes, long path
	row_t rows[19] = '{
		'{32'd0, 32'd5, 1'b1},
		'{32'd7, 32'd0, 1'b1},
		'{32'd0, 32'd0, 1'b1},
		'{32'd1, 32'd1, 1'b1},
		'{32'd9, 32'd9, 1'b1},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
		'{32'd2, 32'd1, 1'b0},
		'{32'd1, 32'd2, 1'b0},
		'{32'd3, 32'd5, 1'b0},
		'{32'd6, 32'd4, 1'b0},
		'{32'hFFFF_FFFF, 32'd1, 1'b0},
		'{32'd1, 32'hFFFF_FFFF, 1'b0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0},
		'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0},
		'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
		'{32'd2971215073, 32'd1836311903, 1'b0},
		'{32'd1836311903, 32'd2971215073, 1'b0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0},
		'{32'h5555_5555, 32'hAAAA_AAAB, 1'b0}
	};

	initial begin
		frac_t f;
		int    phase_items;
		fail_count = 0;
		idle_cycles = 0;
		send_idle_pct = 9;
		recv_stall_pct = 58;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) begin
			f.numerator = rows[i].num;
			f.denominator = rows[i].den;
			send_frac(f, rows[i].typed, typed_answer(rows[i].num, rows[i].den));
		end

		// three idling phases: sender light, then receiver light, then none
		phase_items = N_RANDOM / 3;
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 58;
				recv_stall_pct = 9;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			repeat (phase_items) send_frac(random_frac(), 1'b0, '0);
		end
		@(negedge clk);
		in_ch.valid <= 1'b0;

		// drain, then keep watching for anything stray
		while (runs_due_q.size() != 0 || pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[stern_brocot_path_encode_unit] OK");
		else
			$display("[stern_brocot_path_encode_unit] ERROR");
		$finish;
	end

endmodule
